[hdl/lifo_pkg.sv]
// Shared types and codes for the LIFO stack with reverse.
package lifo_pkg;

  // Command carried by each input item
  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_e;

  // Status reported with each result item
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Source of the result word
  typedef enum logic {
    VAL_ZERO  = 1'b0,
    VAL_RDATA = 1'b1
  } val_sel_e;

  // Source of the last flag
  typedef enum logic {
    LAST_ONE  = 1'b0,
    LAST_DISP = 1'b1
  } last_sel_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned InDataW = 40;   // cmd + push_value, padded to bytes
  localparam int unsigned OutDataW = 40;  // status + out_value, padded to bytes

  // Controller to datapath commands
  typedef struct packed {
    logic      rd_en;     // register read data at port A/B
    logic      rd_top;    // port A reads the top entry instead of the low index
    logic      wr_push;   // write push word at count
    logic      wr_lo;     // write port B data at low index
    logic      wr_hi;     // write port A data at high index
    logic      cnt_inc;
    logic      cnt_dec;
    logic      lo_init;   // low index to bottom, high index to top
    logic      lo_step;   // low index up, high index down
    logic      out_load;  // load the result register
    status_e   out_status;
    val_sel_e  val_sel;
    last_sel_e last_sel;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic lo_ge_hi;
    logic disp_last;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/lifo_dp.sv]
// Datapath: stack memory, count, index registers and result register.
module lifo_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lifo_pkg::ctrl_cmd_t              cmd_i,
  output lifo_pkg::dp_status_t             sts_o,
  input  logic signed [lifo_pkg::WordW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lifo_pkg::status_e                out_status_o,
  output logic signed [lifo_pkg::WordW-1:0] out_value_o,
  output logic                             out_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [lifo_pkg::WordW-1:0] mem [DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0] top_idx, raddr_a, waddr;
  logic [CW-1:0] count_m1;
  logic [lifo_pkg::WordW-1:0] rdata_a_q, rdata_b_q, wdata;
  logic mem_we;

  logic out_valid_q, out_valid_d, out_last_q;
  lifo_pkg::status_e out_status_q;
  logic signed [lifo_pkg::WordW-1:0] out_value_q;

  assign count_m1 = count_q - CW'(1);
  assign top_idx  = count_m1[AW-1:0];

  // Status toward the controller
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.lo_ge_hi  = (lo_q >= hi_q);
  assign sts_o.disp_last = (lo_q == top_idx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Count and index registers
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_m1;
    end
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.lo_init) begin
      lo_d = '0;
      hi_d = top_idx;
    end else if (cmd_i.lo_step) begin
      lo_d = lo_q + AW'(1);
      hi_d = hi_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  // Memory write port: push, or one half of a reverse swap
  assign mem_we = cmd_i.wr_push || cmd_i.wr_lo || cmd_i.wr_hi;

  always_comb begin
    if (cmd_i.wr_push) begin
      waddr = count_q[AW-1:0];
      wdata = push_value_i;
    end else if (cmd_i.wr_lo) begin
      waddr = lo_q;
      wdata = rdata_b_q;
    end else begin
      waddr = hi_q;
      wdata = rdata_a_q;
    end
  end

  assign raddr_a = cmd_i.rd_top ? top_idx : lo_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_a_q <= mem[raddr_a];
      rdata_b_q <= mem[hi_q];
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_value_q  <= (cmd_i.val_sel == lifo_pkg::VAL_RDATA) ? rdata_a_q : '0;
      out_last_q   <= (cmd_i.last_sel == lifo_pkg::LAST_DISP) ? sts_o.disp_last : 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

endmodule

[hdl/lifo_ctrl.sv]
// Controller: command decode and sequencing of pop, display and reverse.
module lifo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lifo_pkg::cmd_e       in_cmd_i,
  input  lifo_pkg::dp_status_t sts_i,
  output lifo_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_OUT,
    S_DISP_RD,
    S_DISP_OUT,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_REV_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d          = state_q;
    cmd_o.rd_en      = 1'b0;
    cmd_o.rd_top     = 1'b0;
    cmd_o.wr_push    = 1'b0;
    cmd_o.wr_lo      = 1'b0;
    cmd_o.wr_hi      = 1'b0;
    cmd_o.cnt_inc    = 1'b0;
    cmd_o.cnt_dec    = 1'b0;
    cmd_o.lo_init    = 1'b0;
    cmd_o.lo_step    = 1'b0;
    cmd_o.out_load   = 1'b0;
    cmd_o.out_status = lifo_pkg::ST_OK;
    cmd_o.val_sel    = lifo_pkg::VAL_ZERO;
    cmd_o.last_sel   = lifo_pkg::LAST_ONE;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            lifo_pkg::CMD_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = lifo_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.wr_push = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            lifo_pkg::CMD_POP: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lifo_pkg::ST_UNDERFLOW;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_top  = 1'b1;
                cmd_o.cnt_dec = 1'b1;
                state_d       = S_POP_OUT;
              end
            end
            lifo_pkg::CMD_DISPLAY: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lifo_pkg::ST_EMPTY;
              end else begin
                cmd_o.lo_init = 1'b1;
                state_d       = S_DISP_RD;
              end
            end
            default: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lifo_pkg::ST_EMPTY;
              end else begin
                cmd_o.lo_init = 1'b1;
                state_d       = S_REV_RD;
              end
            end
          endcase
        end
      end
      S_POP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.val_sel  = lifo_pkg::VAL_RDATA;
          state_d        = S_IDLE;
        end
      end
      S_DISP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.val_sel  = lifo_pkg::VAL_RDATA;
          cmd_o.last_sel = lifo_pkg::LAST_DISP;
          if (sts_i.disp_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.lo_step = 1'b1;
            state_d       = S_DISP_RD;
          end
        end
      end
      S_REV_RD: begin
        if (sts_i.lo_ge_hi) begin
          state_d = S_REV_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_REV_W1;
        end
      end
      S_REV_W1: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = S_REV_W2;
      end
      S_REV_W2: begin
        cmd_o.wr_hi   = 1'b1;
        cmd_o.lo_step = 1'b1;
        state_d       = S_REV_RD;
      end
      S_REV_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/lifo_stack_with_reverse_top.sv]
// Bounded stack of signed 32-bit words with push, pop, display and reverse.
// Push, failed pop and empty display/reverse load their result when accepted; pop reads the top first.
// Display returns each word bottom to top; reverse swaps pairs (read, write low, write high), then reports.
// One item at a time; next item taken in the cycle the last result leaves the output register.
// Reset clears count and control; stack memory stays undefined and needs no clearing.
module lifo_stack_with_reverse_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [1:0] cmd, [33:2] push_value, [39:34] zero
  input  logic [lifo_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [1:0] status, [33:2] out_value, [39:34] zero
  output logic [lifo_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  lifo_pkg::ctrl_cmd_t  cmd;
  lifo_pkg::dp_status_t sts;
  lifo_pkg::cmd_e       in_cmd;
  lifo_pkg::status_e    out_status;
  logic signed [lifo_pkg::WordW-1:0] push_value, out_value;

  // Unpack input item
  assign in_cmd     = lifo_pkg::cmd_e'(s_axis_tdata_i[1:0]);
  assign push_value = s_axis_tdata_i[lifo_pkg::WordW+1:2];

  lifo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (in_cmd),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lifo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .push_value_i (push_value),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack result item
  assign m_axis_tdata_o = {{(lifo_pkg::OutDataW - lifo_pkg::WordW - 2){1'b0}},
                           out_value, out_status};

  // The result register is never overwritten while it still holds an untaken item
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  // A push is written only when there is room
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_push |-> !sts.full)
    else $error("push written into a full stack");

  // A new item is taken only when its result has a place to go
  a_ready_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready while output stalled");

  // Error and empty results are single results, so they carry last
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_status != lifo_pkg::ST_OK)) |-> m_axis_tlast_o)
    else $error("non-ok status without last");

endmodule
